@@ src/bcl_pkg.sv @@
`timescale 1ns / 1ps
package bcl_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int CNT_W   = 6;
  localparam int VIDX_W  = 6;
  localparam int LABEL_W = 7;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             adjacent;
  } bcl_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  vertex_index;
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] label_count;
    logic               last;
  } bcl_out_t;

  // one bit write into the adjacency store
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
  } bcl_adj_wr_t;

endpackage

@@ src/bcl_adj_store.sv @@
`timescale 1ns / 1ps
module bcl_adj_store #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  bcl_pkg::bcl_adj_wr_t                       wr,
  input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
  output logic [MAX_COLS-1:0]                        rd_data
);
  import bcl_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // one word per row, bit per column
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;

  logic                wr_ok;
  logic [RIW-1:0]      wr_ridx;
  logic [CIW-1:0]      wr_cidx;
  logic [MAX_COLS-1:0] fresh_word;

  always_comb begin
    wr_ok   = wr.en && (32'(wr.row) < MAX_ROWS) && (32'(wr.col) < MAX_COLS);
    wr_ridx = RIW'(wr.row);
    wr_cidx = CIW'(wr.col);
    fresh_word = '0;
    fresh_word[wr_cidx] = wr.value;
  end

  // a row not yet written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_ok) begin
      row_vld_r[wr_ridx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      if (row_vld_r[wr_ridx]) begin
        mem[wr_ridx][wr_cidx] <= wr.value;
      end else begin
        mem[wr_ridx] <= fresh_word;
      end
    end
    rd_data <= row_vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

@@ src/bipartite_component_labeler.sv @@
`timescale 1ns / 1ps
// Bipartite component labeler. Load requests (action 0) write one bit of the
// row by column adjacency store. A compute request (action 1) labels the
// connected components over the rows and columns in use, then emits one
// result per vertex, rows first, then columns, each with the total label
// count, the final one flagged last. Components are numbered in order of
// their lowest row; rows with no edge take a label of their own in turn,
// then unlabelled columns in column order. The work is done by sweeps over
// the adjacency store, one row word read at a time: each new component is
// swept until a sweep adds no row, then its columns are stamped; the outer
// scan visits every row and the column pass every column. Each result is
// read from the label memory and held until taken before the next is read.
// Input is stalled from the compute request until the last result has been
// taken.
module bipartite_component_labeler #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bcl_pkg::bcl_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bcl_pkg::bcl_out_t    out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [bcl_pkg::CNT_W-1:0] cfg_wdata
);
  import bcl_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int VAW = $clog2(MAX_ROWS + MAX_COLS);
  localparam int VCW = $clog2(MAX_ROWS + MAX_COLS + 1);
  localparam int NV  = MAX_ROWS + MAX_COLS;

  typedef enum logic [3:0] {
    IDLE, ROW_RD, ROW_CHK, FL_RD, FL_CHK, COLW, COL_SCAN,
    EMIT_RD, EMIT_WAIT, EMIT_OUT
  } state_t;

  state_t              state_r;
  logic [RCW-1:0]      rc_r;
  logic [CCW-1:0]      cc_r;
  logic [RCW-1:0]      row_i_r;
  logic [RCW-1:0]      k_r;
  logic [CCW-1:0]      c_r;
  logic [VAW-1:0]      vi_r;
  logic [LABEL_W-1:0]  cnt_r;
  logic                changed_r;
  logic [MAX_COLS-1:0] colset_r;
  logic [MAX_ROWS-1:0] row_lab_r;
  logic [MAX_COLS-1:0] col_lab_r;

  // label memory, rows then columns
  logic [LABEL_W-1:0]  lab_mem [NV];
  logic [LABEL_W-1:0]  lab_q;
  logic                lw_en;
  logic [VAW-1:0]      lw_addr;
  logic [LABEL_W-1:0]  lw_data;

  bcl_adj_wr_t         adj_wr;
  logic [RIW-1:0]      adj_rd_addr;
  logic [MAX_COLS-1:0] adj_rd_data;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] adj_w;
  logic                hit;
  logic                in_acc;
  logic [VCW-1:0]      total;
  logic [VAW-1:0]      col_vaddr;
  logic [CIW-1:0]      c_idx;
  logic [CNT_W-1:0]    cfg_clamp_r;
  logic [CNT_W-1:0]    cfg_clamp_c;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != IDLE);
  assign total    = VCW'(rc_r) + VCW'(cc_r);
  assign c_idx    = CIW'(c_r);
  assign col_vaddr = VAW'(rc_r) + VAW'(c_r);

  // count registers clamp to 1..max
  always_comb begin
    cfg_clamp_r = cfg_wdata;
    if (cfg_wdata == '0) cfg_clamp_r = CNT_W'(1);
    else if (32'(cfg_wdata) > MAX_ROWS) cfg_clamp_r = CNT_W'(MAX_ROWS);
    cfg_clamp_c = cfg_wdata;
    if (cfg_wdata == '0) cfg_clamp_c = CNT_W'(1);
    else if (32'(cfg_wdata) > MAX_COLS) cfg_clamp_c = CNT_W'(MAX_COLS);
  end

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (32'(cc_r) > j);
    end
    adj_w = adj_rd_data & col_mask;
    hit   = |(adj_w & colset_r);
  end

  always_comb begin
    adj_wr.en    = in_acc && (in_data.action == ACT_LOAD);
    adj_wr.row   = in_data.row;
    adj_wr.col   = in_data.col;
    adj_wr.value = in_data.adjacent;
    adj_rd_addr  = (state_r == FL_RD) ? RIW'(k_r) : RIW'(row_i_r);
  end

  bcl_adj_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (adj_wr),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  // label memory write port
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = VAW'(row_i_r);
    lw_data = cnt_r + LABEL_W'(1);
    case (state_r)
      ROW_CHK: begin
        lw_en = 1'b1;
      end
      FL_CHK: begin
        lw_en   = hit;
        lw_addr = VAW'(k_r);
        lw_data = cnt_r;
      end
      COLW: begin
        lw_en   = (c_r != cc_r) && colset_r[c_idx] && !col_lab_r[c_idx];
        lw_addr = col_vaddr;
        lw_data = cnt_r;
      end
      COL_SCAN: begin
        lw_en   = (c_r != cc_r) && !col_lab_r[c_idx];
        lw_addr = col_vaddr;
      end
      default: begin
        lw_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      lab_mem[lw_addr] <= lw_data;
    end
    lab_q <= lab_mem[vi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      rc_r      <= RCW'(MAX_ROWS);
      cc_r      <= CCW'(MAX_COLS);
      row_i_r   <= '0;
      k_r       <= '0;
      c_r       <= '0;
      vi_r      <= '0;
      cnt_r     <= '0;
      changed_r <= 1'b0;
      colset_r  <= '0;
      row_lab_r <= '0;
      col_lab_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ROW_COUNT) rc_r <= RCW'(cfg_clamp_r);
        else if (cfg_index == CFG_COL_COUNT) cc_r <= CCW'(cfg_clamp_c);
      end
      case (state_r)
        IDLE: begin
          if (in_acc && in_data.action == ACT_COMPUTE) begin
            row_lab_r <= '0;
            col_lab_r <= '0;
            cnt_r     <= '0;
            row_i_r   <= '0;
            state_r   <= ROW_RD;
          end
        end
        // outer row scan
        ROW_RD: begin
          if (row_i_r == rc_r) begin
            c_r     <= '0;
            state_r <= COL_SCAN;
          end else if (row_lab_r[RIW'(row_i_r)]) begin
            row_i_r <= row_i_r + RCW'(1);
          end else begin
            state_r <= ROW_CHK;
          end
        end
        ROW_CHK: begin
          cnt_r <= cnt_r + LABEL_W'(1);
          row_lab_r[RIW'(row_i_r)] <= 1'b1;
          if (adj_w == '0) begin
            row_i_r <= row_i_r + RCW'(1);
            state_r <= ROW_RD;
          end else begin
            colset_r  <= adj_w;
            k_r       <= '0;
            changed_r <= 1'b0;
            state_r   <= FL_RD;
          end
        end
        // flood sweeps: pull in rows touching the column set until stable
        FL_RD: begin
          if (k_r == rc_r) begin
            k_r       <= '0;
            changed_r <= 1'b0;
            if (!changed_r) begin
              c_r     <= '0;
              state_r <= COLW;
            end
          end else if (row_lab_r[RIW'(k_r)]) begin
            k_r <= k_r + RCW'(1);
          end else begin
            state_r <= FL_CHK;
          end
        end
        FL_CHK: begin
          if (hit) begin
            colset_r  <= colset_r | adj_w;
            row_lab_r[RIW'(k_r)] <= 1'b1;
            changed_r <= 1'b1;
          end
          k_r     <= k_r + RCW'(1);
          state_r <= FL_RD;
        end
        // stamp the component's columns
        COLW: begin
          if (c_r == cc_r) begin
            row_i_r <= row_i_r + RCW'(1);
            state_r <= ROW_RD;
          end else begin
            if (colset_r[c_idx]) col_lab_r[c_idx] <= 1'b1;
            c_r <= c_r + CCW'(1);
          end
        end
        // leftover columns each get a label
        COL_SCAN: begin
          if (c_r == cc_r) begin
            vi_r    <= '0;
            state_r <= EMIT_RD;
          end else begin
            if (!col_lab_r[c_idx]) begin
              cnt_r <= cnt_r + LABEL_W'(1);
              col_lab_r[c_idx] <= 1'b1;
            end
            c_r <= c_r + CCW'(1);
          end
        end
        EMIT_RD: begin
          state_r <= EMIT_WAIT;
        end
        EMIT_WAIT: begin
          out_data.vertex_index <= VIDX_W'(vi_r);
          out_data.label        <= lab_q;
          out_data.label_count  <= cnt_r;
          out_data.last         <= (VCW'(vi_r) + VCW'(1) == total);
          out_valid             <= 1'b1;
          state_r               <= EMIT_OUT;
        end
        EMIT_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_data.last) begin
              state_r <= IDLE;
            end else begin
              vi_r    <= vi_r + VAW'(1);
              state_r <= EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  // no result is shown while new requests are taken
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result valid while input open");

  // a flood always works on a non-empty column set
  a_flood_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FL_CHK) |-> (colset_r != '0))
    else $error("flood with empty column set");

  // a result label never exceeds the count of labels handed out
  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.label != '0) && (out_data.label <= out_data.label_count))
    else $error("label out of range");

endmodule
